### sv/codon_usage_histogram_assert.svh
// ----------------------------------------------------------------------------
// Codon usage histogram assertion macros
// Shared property forms for the checks in the histogram RTL.
// ----------------------------------------------------------------------------
`ifndef CODON_USAGE_HISTOGRAM_ASSERT_SVH
`define CODON_USAGE_HISTOGRAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CUH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CUH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cuh_pkg.sv
// ----------------------------------------------------------------------------
// Codon usage histogram package
// Item types, command codes and the codon decode tables.
// ----------------------------------------------------------------------------
package cuh_pkg;

    localparam int NUM_CODONS  = 64;
    localparam int NUM_AMINOS  = 22;
    localparam int CODON_W     = 6;
    localparam int AMINO_W     = 5;
    localparam int BASE_W      = 8;
    localparam int CMD_W       = 2;
    localparam int OUT_COUNT_W = 32;

    localparam logic [BASE_W-1:0] ASCII_A = 8'h41;
    localparam logic [BASE_W-1:0] ASCII_C = 8'h43;
    localparam logic [BASE_W-1:0] ASCII_G = 8'h47;
    localparam logic [BASE_W-1:0] ASCII_T = 8'h54;
    localparam logic [BASE_W-1:0] ASCII_U = 8'h55;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 2'd0,
        CMD_COUNT      = 2'd1,
        CMD_READ_CODON = 2'd2,
        CMD_READ_AMINO = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BASE_W-1:0]  base_first;
        logic [BASE_W-1:0]  base_second;
        logic [BASE_W-1:0]  base_third;
        logic [CODON_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [CODON_W-1:0]     codon_index;
        logic [AMINO_W-1:0]     amino_index;
        logic                   item_valid;
        logic [OUT_COUNT_W-1:0] count_value;
    } t_out_item;

    // Result of decoding one codon.
    typedef struct packed {
        logic               ok;
        logic [CODON_W-1:0] cidx;
        logic [AMINO_W-1:0] aidx;
    } t_dec;

    // Table position of each codon, indexed by its natural base-4 code
    // (A=0, C=1, G=2, T=3, first base most significant).
    localparam logic [CODON_W-1:0] CODON_POS [NUM_CODONS] = '{
        6'd21, 6'd30, 6'd22, 6'd31, 6'd48, 6'd49, 6'd50, 6'd51,
        6'd38, 6'd60, 6'd39, 6'd59, 6'd18, 6'd19, 6'd29, 6'd20,
        6'd36, 6'd16, 6'd37, 6'd17, 6'd32, 6'd33, 6'd34, 6'd35,
        6'd40, 6'd41, 6'd42, 6'd43, 6'd23, 6'd24, 6'd25, 6'd26,
        6'd8,  6'd6,  6'd9,  6'd7,  6'd0,  6'd1,  6'd2,  6'd3,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd52, 6'd53, 6'd54, 6'd55,
        6'd61, 6'd57, 6'd62, 6'd58, 6'd44, 6'd45, 6'd46, 6'd47,
        6'd63, 6'd4,  6'd56, 6'd5,  6'd27, 6'd10, 6'd28, 6'd11
    };

    // Amino-acid group of each table position.
    localparam logic [AMINO_W-1:0] AMINO_OF_POS [NUM_CODONS] = '{
        5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd2,
        5'd3,  5'd3,  5'd4,  5'd4,  5'd5,  5'd5,  5'd5,  5'd5,
        5'd6,  5'd6,  5'd7,  5'd7,  5'd7,  5'd8,  5'd8,  5'd9,
        5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd10, 5'd11, 5'd11,
        5'd12, 5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14,
        5'd14, 5'd14, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15, 5'd15,
        5'd16, 5'd16, 5'd16, 5'd16, 5'd17, 5'd17, 5'd17, 5'd17,
        5'd18, 5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21
    };

    // Returns {ok, 2-bit base code}; U is taken as T.
    function automatic logic [2:0] norm_base(input logic [BASE_W-1:0] b);
        logic [2:0] r;
        case (b)
            ASCII_A: r = 3'b100;
            ASCII_C: r = 3'b101;
            ASCII_G: r = 3'b110;
            ASCII_T: r = 3'b111;
            ASCII_U: r = 3'b111;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

### sv/cuh_ram.sv
// ----------------------------------------------------------------------------
// Codon usage histogram counter memory
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cuh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read-first: a read of the entry written at the same edge returns old data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/cuh_decode.sv
// ----------------------------------------------------------------------------
// Codon usage histogram codon decoder
// Maps three ASCII bases to table position and amino-acid group.
// ----------------------------------------------------------------------------
module cuh_decode (
    input  logic [cuh_pkg::BASE_W-1:0] i_base_first,
    input  logic [cuh_pkg::BASE_W-1:0] i_base_second,
    input  logic [cuh_pkg::BASE_W-1:0] i_base_third,
    output cuh_pkg::t_dec              o_dec
);
    import cuh_pkg::*;

    logic [2:0]         w_b1;
    logic [2:0]         w_b2;
    logic [2:0]         w_b3;
    logic [CODON_W-1:0] w_nat;
    logic [CODON_W-1:0] w_pos;

    always_comb begin
        w_b1  = norm_base(i_base_first);
        w_b2  = norm_base(i_base_second);
        w_b3  = norm_base(i_base_third);
        w_nat = {w_b1[1:0], w_b2[1:0], w_b3[1:0]};
        w_pos = CODON_POS[w_nat];
        o_dec.ok = w_b1[2] & w_b2[2] & w_b3[2];
        // Invalid codons report index zero.
        o_dec.cidx = o_dec.ok ? w_pos : '0;
        o_dec.aidx = o_dec.ok ? AMINO_OF_POS[w_pos] : '0;
    end

endmodule

### sv/codon_usage_histogram.sv
// ----------------------------------------------------------------------------
// Codon usage histogram
// Decodes codons, keeps saturating codon and amino-acid counters in RAM.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//
//  The block takes one item per cycle when the output side keeps up; the
//  counter RAMs are read at acceptance into the update stage, and the
//  read-modify-write completes from there into the output register once
//  that register is free.
//  Reset is synchronous and active low; it clears all counters at once by
//  dropping the per-entry valid bits, so no clearing pass is needed.
//  A stalled output holds the result register, then the update stage, and
//  the input stalls only when both are full.
//
module codon_usage_histogram #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cuh_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cuh_pkg::t_out_item o_out_item
);
    import cuh_pkg::*;

    `include "codon_usage_histogram_assert.svh"

    // Saturating increment of one counter.
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // ------------------------------------------------------------------
    // Acceptance and decode
    // ------------------------------------------------------------------
    t_dec                w_dec;
    logic                w_accept;
    logic                w_out_free;
    logic                w_s1_free;
    logic                w_s1_adv;
    logic                w_in_ok;
    logic [CODON_W-1:0]  w_rd_caddr;
    logic [AMINO_W-1:0]  w_rd_aaddr;
    logic                r_s1_valid;

    cuh_decode u_decode (
        .i_base_first  (i_in_item.base_first),
        .i_base_second (i_in_item.base_second),
        .i_base_third  (i_in_item.base_third),
        .o_dec         (w_dec)
    );

    // The output register is free when empty or being taken this cycle.
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign o_in_stall = !w_s1_free;
    assign w_accept   = i_in_valid && w_s1_free;

    // Work out which counter entries this item touches.
    always_comb begin
        w_in_ok    = 1'b1;
        w_rd_caddr = '0;
        w_rd_aaddr = '0;
        case (i_in_item.cmd)
            CMD_CLEAR: begin
                w_in_ok = 1'b1;
            end
            CMD_COUNT: begin
                w_in_ok    = w_dec.ok;
                w_rd_caddr = w_dec.cidx;
                w_rd_aaddr = w_dec.aidx;
            end
            CMD_READ_CODON: begin
                w_rd_caddr = i_in_item.read_index;
            end
            CMD_READ_AMINO: begin
                w_in_ok = (i_in_item.read_index < CODON_W'(NUM_AMINOS));
                // Out-of-range reads use entry zero; their value is dropped.
                w_rd_aaddr = w_in_ok ? i_in_item.read_index[AMINO_W-1:0] : '0;
            end
            default: begin
                w_in_ok = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Update stage: counter RAMs and their valid bits
    // ------------------------------------------------------------------
    logic [CMD_W-1:0]       r_s1_cmd;
    logic                   r_s1_ok;
    logic [CODON_W-1:0]     r_s1_caddr;
    logic [AMINO_W-1:0]     r_s1_aaddr;

    logic [NUM_CODONS-1:0]  r_cval;
    logic [NUM_AMINOS-1:0]  r_aval;

    logic                   r_fwd_c_en;
    logic [CODON_W-1:0]     r_fwd_c_addr;
    logic [COUNT_WIDTH-1:0] r_fwd_c_data;
    logic                   r_fwd_a_en;
    logic [AMINO_W-1:0]     r_fwd_a_addr;
    logic [COUNT_WIDTH-1:0] r_fwd_a_data;

    logic [COUNT_WIDTH-1:0] w_c_rd;
    logic [COUNT_WIDTH-1:0] w_a_rd;
    logic [COUNT_WIDTH-1:0] w_cur_c;
    logic [COUNT_WIDTH-1:0] w_cur_a;
    logic [COUNT_WIDTH-1:0] w_new_c;
    logic [COUNT_WIDTH-1:0] w_new_a;
    logic                   w_wr;
    logic                   w_clr;

    cuh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_CODONS)
    ) u_codon_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_caddr),
        .o_rd_data (w_c_rd),
        .i_wr_en   (w_wr),
        .i_wr_addr (r_s1_caddr),
        .i_wr_data (w_new_c)
    );

    cuh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_AMINOS)
    ) u_amino_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_aaddr),
        .o_rd_data (w_a_rd),
        .i_wr_en   (w_wr),
        .i_wr_addr (r_s1_aaddr),
        .i_wr_data (w_new_a)
    );

    // The RAM data was read at acceptance. A write to the same entry at that
    // very edge is not in it yet, so the last write is forwarded. An entry
    // whose valid bit is low was cleared and reads as zero.
    always_comb begin
        if (r_fwd_c_en && (r_fwd_c_addr == r_s1_caddr)) begin
            w_cur_c = r_fwd_c_data;
        end else begin
            w_cur_c = r_cval[r_s1_caddr] ? w_c_rd : '0;
        end
        if (r_fwd_a_en && (r_fwd_a_addr == r_s1_aaddr)) begin
            w_cur_a = r_fwd_a_data;
        end else begin
            w_cur_a = r_aval[r_s1_aaddr] ? w_a_rd : '0;
        end
        w_new_c = sat_inc(w_cur_c);
        w_new_a = sat_inc(w_cur_a);
    end

    assign w_wr  = w_s1_adv && (r_s1_cmd == CMD_COUNT) && r_s1_ok;
    assign w_clr = w_s1_adv && (r_s1_cmd == CMD_CLEAR);

    // ------------------------------------------------------------------
    // Result formatting
    // ------------------------------------------------------------------
    t_out_item n_out_item;

    always_comb begin
        n_out_item = '0;
        case (r_s1_cmd)
            CMD_CLEAR: begin
                n_out_item.item_valid = 1'b1;
            end
            CMD_COUNT: begin
                if (r_s1_ok) begin
                    n_out_item.codon_index = r_s1_caddr;
                    n_out_item.amino_index = r_s1_aaddr;
                    n_out_item.item_valid  = 1'b1;
                    n_out_item.count_value = OUT_COUNT_W'(w_new_c);
                end
            end
            CMD_READ_CODON: begin
                n_out_item.item_valid  = 1'b1;
                n_out_item.count_value = OUT_COUNT_W'(w_cur_c);
            end
            CMD_READ_AMINO: begin
                if (r_s1_ok) begin
                    n_out_item.item_valid  = 1'b1;
                    n_out_item.count_value = OUT_COUNT_W'(w_cur_a);
                end
            end
            default: begin
                n_out_item = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic      r_out_valid;
    t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cval      <= '0;
            r_aval      <= '0;
            r_fwd_c_en  <= 1'b0;
            r_fwd_a_en  <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= w_accept;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_clr) begin
                r_cval <= '0;
                r_aval <= '0;
            end else if (w_wr) begin
                r_cval[r_s1_caddr] <= 1'b1;
                r_aval[r_s1_aaddr] <= 1'b1;
            end
            // The forwarded write only changes when the update stage moves,
            // so a stalled item still sees the write that raced its read.
            if (w_s1_adv) begin
                r_fwd_c_en <= w_wr;
                r_fwd_a_en <= w_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd   <= i_in_item.cmd;
            r_s1_ok    <= w_in_ok;
            r_s1_caddr <= w_rd_caddr;
            r_s1_aaddr <= w_rd_aaddr;
        end
        if (w_s1_adv) begin
            r_out_item   <= n_out_item;
            r_fwd_c_addr <= r_s1_caddr;
            r_fwd_c_data <= w_new_c;
            r_fwd_a_addr <= r_s1_aaddr;
            r_fwd_a_data <= w_new_a;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CUH_ASSERT_NEXT(a_clear_drops_valid, i_clk, i_rst_n, w_clr,
        (r_cval == '0) && (r_aval == '0), "clear left a counter valid")
    `CUH_ASSERT_NEXT(a_write_sets_valid, i_clk, i_rst_n, w_wr,
        r_fwd_c_en && r_cval[r_fwd_c_addr] && r_aval[r_fwd_a_addr],
        "counter write did not mark its entries valid")
    `CUH_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_s1_valid && !w_out_free,
        r_s1_valid && $stable(r_s1_caddr) && $stable(r_s1_cmd),
        "update stage changed while output stalled")
    `CUH_ASSERT_NOW(a_amino_addr_range, i_clk, i_rst_n, r_s1_valid,
        r_s1_aaddr < AMINO_W'(NUM_AMINOS), "amino counter address out of range")
    `CUH_ASSERT_NOW(a_invalid_is_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.item_valid,
        (o_out_item.count_value == '0) && (o_out_item.codon_index == '0),
        "invalid result carries data")

endmodule

### dv/tb_codon_usage_histogram.sv
// ----------------------------------------------------------------------------
// Codon usage histogram testbench
// Streams count, clear and read commands through the histogram with random
// gaps on the input and random back-pressure on the output. A local model of
// the codon decode and the saturating counters predicts every result, and
// the results are checked field by field in order. Counters are built at
// their default width.
// ----------------------------------------------------------------------------
module tb_codon_usage_histogram;

    import cuh_pkg::*;

    // Counter width of the default build.
    localparam int TALLY_W      = 32;
    localparam int RANDOM_ITEMS = 1030;
    localparam int LONG_RUN_LEN = 270;
    localparam int QUIET_TAIL   = 150;

    // Codon table in amino-acid group order, three ASCII characters each.
    // The first codon sits in the most significant bits.
    localparam logic [NUM_CODONS*24-1:0] CODON_LIST = {
        "GCAGCCGCGGCT", "TGCTGT", "GACGAT", "GAAGAG", "TTCTTT",
        "GGAGGCGGGGGT", "CACCAT", "ATAATCATT", "AAAAAG",
        "CTACTCCTGCTTTTATTG", "ATG", "AACAAT", "CCACCCCCGCCT", "CAACAG",
        "AGAAGGCGACGCCGGCGT", "TCATCCTCGTCT", "ACAACCACGACT",
        "GTAGTCGTGGTT", "TGG", "TACTAT", "AGTAGC", "TAATAGTGA"
    };

    // Number of codons in each amino-acid group, first group in the top bits.
    localparam logic [NUM_AMINOS*4-1:0] GROUP_SIZES = {
        4'd4, 4'd2, 4'd2, 4'd2, 4'd2, 4'd4, 4'd2, 4'd3, 4'd2, 4'd6, 4'd1,
        4'd2, 4'd4, 4'd2, 4'd6, 4'd4, 4'd4, 4'd4, 4'd1, 4'd2, 4'd2, 4'd3
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;

    // Local copy of the counters.
    logic [TALLY_W-1:0] codon_tally [NUM_CODONS];
    logic [TALLY_W-1:0] amino_tally [NUM_AMINOS];

    t_in_item  pending_items [$];
    t_out_item expected_results [$];

    bit in_taken       = 1'b0;
    int send_gap       = 0;
    int stall_gap      = 0;
    int idle_pct       = 20;
    int accepted_count = 0;
    int mismatch_count = 0;

    codon_usage_histogram #(
        .COUNT_WIDTH (TALLY_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // U reads as T; any other byte passes through, so a non-base byte matches no codon.
    function automatic logic [7:0] fold_base(input logic [7:0] b);
        return (b == "U") ? "T" : b;
    endfunction

    function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] v);
        return (v == {TALLY_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Applies one command to the local counters and returns its result.
    function automatic t_out_item apply_command(input t_in_item it);
        t_out_item   res;
        logic [23:0] key;
        int          pos;
        int          grp;
        int          bound;
        int          k;
        res = '0;
        case (it.cmd)
            CMD_CLEAR: begin
                for (k = 0; k < NUM_CODONS; k++) codon_tally[k] = '0;
                for (k = 0; k < NUM_AMINOS; k++) amino_tally[k] = '0;
                res.item_valid = 1'b1;
            end
            CMD_COUNT: begin
                key = {fold_base(it.base_first), fold_base(it.base_second),
                       fold_base(it.base_third)};
                pos = -1;
                for (k = 0; k < NUM_CODONS; k++) begin
                    if (CODON_LIST[(NUM_CODONS-1-k)*24 +: 24] == key) pos = k;
                end
                if (pos >= 0) begin
                    // Walk the group sizes to find the amino acid of this slot.
                    grp   = 0;
                    bound = int'(GROUP_SIZES[(NUM_AMINOS-1)*4 +: 4]);
                    while (pos >= bound) begin
                        grp++;
                        bound += int'(GROUP_SIZES[(NUM_AMINOS-1-grp)*4 +: 4]);
                    end
                    codon_tally[pos] = bump(codon_tally[pos]);
                    amino_tally[grp] = bump(amino_tally[grp]);
                    res.codon_index  = CODON_W'(pos);
                    res.amino_index  = AMINO_W'(grp);
                    res.item_valid   = 1'b1;
                    res.count_value  = OUT_COUNT_W'(codon_tally[pos]);
                end
            end
            CMD_READ_CODON: begin
                res.item_valid  = 1'b1;
                res.count_value = OUT_COUNT_W'(codon_tally[it.read_index]);
            end
            default: begin
                if (it.read_index < NUM_AMINOS) begin
                    res.item_valid  = 1'b1;
                    res.count_value = OUT_COUNT_W'(amino_tally[it.read_index]);
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_in_item make_item(input t_cmd c, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [CODON_W-1:0] idx);
        t_in_item it;
        it.cmd         = c;
        it.base_first  = b1;
        it.base_second = b2;
        it.base_third  = b3;
        it.read_index  = idx;
        return it;
    endfunction

    function automatic logic [7:0] rand_base();
        case ($urandom_range(0, 4))
            0:       return "A";
            1:       return "C";
            2:       return "G";
            3:       return "T";
            default: return "U";
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [CODON_W-1:0] rand_index();
        return CODON_W'($urandom);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Input driver: a new item goes out only once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_items.size() >= QUIET_TAIL &&
                         $urandom_range(0, 99) < idle_pct) begin
                send_gap = $urandom_range(0, 10);
                i_in_valid <= 1'b0;
            end else begin
                i_in_item  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // Output back-pressure in bursts, switched off near the end of the run.
    always @(negedge i_clk) begin
        if (stall_gap > 0) begin
            stall_gap--;
            i_out_stall <= 1'b1;
        end else if (pending_items.size() >= QUIET_TAIL &&
                     $urandom_range(0, 99) < idle_pct) begin
            stall_gap = $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: predicts each accepted item, then checks each delivered result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                expected_results.push_back(apply_command(i_in_item));
                accepted_count++;
                // Change the idling density now and then; a quarter of the
                // phases have none at all.
                if (accepted_count % 64 == 0) begin
                    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("codon_index", 32'(want.codon_index),
                                32'(o_out_item.codon_index));
                    check_field("amino_index", 32'(want.amino_index),
                                32'(o_out_item.amino_index));
                    check_field("item_valid", 32'(want.item_valid),
                                32'(o_out_item.item_valid));
                    check_field("count_value", want.count_value, o_out_item.count_value);
                end
            end
        end else begin
            in_taken = 1'b0;
        end
    end

    initial begin
        t_in_item   it;
        logic [7:0] b1, b2, b3, bad;
        int         n, k, pick, run_len;
        bit         long_run_done;

        for (k = 0; k < NUM_CODONS; k++) codon_tally[k] = '0;
        for (k = 0; k < NUM_AMINOS; k++) amino_tally[k] = '0;

        // Directed items: first and last table slots, the cysteine and tyrosine
        // neighbors, the out-of-order serine pair, U spelling, bad bytes,
        // reads at the index limits and a clear between counts.
        pending_items.push_back(make_item(CMD_CLEAR, rand_byte(), rand_byte(), rand_byte(),
                                          rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "G", "C", "A", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "T", "G", "A", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "U", "G", "U", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "T", "A", "T", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "A", "G", "T", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "A", "G", "C", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "U", "U", "U", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "A", "T", "G", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, 8'h00, "C", "A", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "G", "C", 8'hFF, rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "G", "a", "A", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "N", "N", "N", rand_index()));
        pending_items.push_back(make_item(CMD_COUNT, "G", "C", "A", rand_index()));
        pending_items.push_back(make_item(CMD_READ_CODON, rand_byte(), rand_byte(), rand_byte(),
                                          6'd0));
        pending_items.push_back(make_item(CMD_READ_CODON, rand_byte(), rand_byte(), rand_byte(),
                                          6'd63));
        pending_items.push_back(make_item(CMD_READ_AMINO, rand_byte(), rand_byte(), rand_byte(),
                                          6'd0));
        pending_items.push_back(make_item(CMD_READ_AMINO, rand_byte(), rand_byte(), rand_byte(),
                                          6'd21));
        pending_items.push_back(make_item(CMD_READ_AMINO, rand_byte(), rand_byte(), rand_byte(),
                                          6'd22));
        pending_items.push_back(make_item(CMD_READ_AMINO, rand_byte(), rand_byte(), rand_byte(),
                                          6'd63));
        pending_items.push_back(make_item(CMD_CLEAR, rand_byte(), rand_byte(), rand_byte(),
                                          rand_index()));
        pending_items.push_back(make_item(CMD_READ_CODON, rand_byte(), rand_byte(), rand_byte(),
                                          6'd0));
        pending_items.push_back(make_item(CMD_READ_AMINO, rand_byte(), rand_byte(), rand_byte(),
                                          6'd1));
        pending_items.push_back(make_item(CMD_COUNT, "T", "G", "T", rand_index()));

        // Random part: mostly well-formed codons, with runs of one codon to
        // exercise back-to-back updates of the same counter, and one long run
        // of a single codon followed by a read of every amino counter.
        n = 0;
        long_run_done = 1'b0;
        while (n < RANDOM_ITEMS) begin
            if (n >= 300 && !long_run_done) begin
                long_run_done = 1'b1;
                b1 = rand_base();
                b2 = rand_base();
                b3 = rand_base();
                for (k = 0; k < LONG_RUN_LEN; k++) begin
                    pending_items.push_back(make_item(CMD_COUNT, b1, b2, b3, rand_index()));
                end
                for (k = 0; k < NUM_AMINOS; k++) begin
                    pending_items.push_back(make_item(CMD_READ_AMINO, rand_byte(), rand_byte(),
                                                      rand_byte(), CODON_W'(k)));
                end
                n += LONG_RUN_LEN + NUM_AMINOS;
            end else begin
                pick = $urandom_range(0, 99);
                b1 = rand_base();
                b2 = rand_base();
                b3 = rand_base();
                if (pick < 55) begin
                    it = make_item(CMD_COUNT, b1, b2, b3, rand_index());
                    n++;
                end else if (pick < 63) begin
                    // One corrupted base: a random byte or a lowercase letter.
                    bad = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                               : (rand_base() | 8'h20);
                    case ($urandom_range(0, 2))
                        0:       b1 = bad;
                        1:       b2 = bad;
                        default: b3 = bad;
                    endcase
                    it = make_item(CMD_COUNT, b1, b2, b3, rand_index());
                    n++;
                end else if (pick < 78) begin
                    it = make_item(CMD_READ_CODON, rand_byte(), rand_byte(), rand_byte(),
                                   rand_index());
                    n++;
                end else if (pick < 93) begin
                    it = make_item(CMD_READ_AMINO, rand_byte(), rand_byte(), rand_byte(),
                                   CODON_W'($urandom_range(0, 1) ? $urandom_range(0, 21)
                                                                 : $urandom_range(0, 63)));
                    n++;
                end else if (pick < 95) begin
                    it = make_item(CMD_CLEAR, rand_byte(), rand_byte(), rand_byte(),
                                   rand_index());
                    n++;
                end else begin
                    run_len = $urandom_range(8, 40);
                    for (k = 1; k < run_len; k++) begin
                        pending_items.push_back(make_item(CMD_COUNT, b1, b2, b3, rand_index()));
                    end
                    it = make_item(CMD_COUNT, b1, b2, b3, rand_index());
                    n += run_len;
                end
                pending_items.push_back(it);
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        // Leave room for any stray result.
        repeat (10) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_codon_usage_histogram passed");
        end else begin
            $display("tb_codon_usage_histogram failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_codon_usage_histogram failed");
        $finish;
    end

endmodule
